// ===== sv/ohs_pkg.sv =====
// shared types, constants and codes of the open-addressing hash set
// no dependencies; imported by every module of the block but ohs_ram

package ohs_pkg;

  // table geometry
  localparam int unsigned MAX_SLOTS = 4096;
  localparam int unsigned MIN_SLOTS = 8;
  localparam int unsigned SLOT_AW   = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = SLOT_AW + 1;
  localparam int unsigned KEY_W     = 31;
  localparam int unsigned ENTRY_W   = KEY_W + 1;
  localparam int unsigned SIZE_W    = CNT_W + 4;
  localparam int unsigned TGT_W     = CNT_W + 3;

  // probe and growth constants
  localparam int unsigned LINEAR_RUN    = 9;
  localparam int unsigned PERTURB_SHIFT = 5;
  localparam int unsigned BIG_SET       = 50000;
  localparam int unsigned RUN_W         = 4;

  // stream payload widths
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SPARE  = 2'd3
  } ohs_cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_OVF_REJ   = 3'd2,
    ST_KEY_READ  = 3'd3,
    ST_READ_EXH  = 3'd4,
    ST_CLEARED   = 3'd5
  } ohs_status_e;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_CLR, S_PRB_RD, S_PRB_CHK, S_GROW_CHK,
    S_GROW_SIZE, S_GCLR, S_SCAN_RD, S_SCAN_CHK, S_SCAN_NEXT, S_COPY_RD,
    S_COPY_WR, S_RD_RD, S_RD_CHK, S_DONE
  } ohs_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT_WR, OP_ACCEPT, OP_CLR_WR, OP_RES_OVF, OP_PRB_RD,
    OP_PRB_CHK, OP_SIZE_INIT, OP_SIZE_STEP, OP_SET_OVF, OP_GROW_BEGIN,
    OP_GCLR_WR, OP_SCAN_RD, OP_PLACE_BEGIN, OP_SCAN_NEXT, OP_COPY_RD,
    OP_COPY_WR, OP_RD_RD, OP_RD_EXH, OP_RD_HIT, OP_RD_NEXT, OP_LOAD_OUT
  } ohs_op_e;

  // status from datapath to controller
  typedef struct packed {
    ohs_cmd_e cmd;
    logic     ovf;
    logic     place;
    logic     prb_empty;
    logic     prb_match;
    logic     slot_valid;
    logic     grow_need;
    logic     size_done;
    logic     size_big;
    logic     cnt_max_last;
    logic     cnt_mask_last;
    logic     cnt_nmask_last;
    logic     rd_end;
    logic     out_busy;
  } ohs_dp_status_t;

endpackage

// ===== sv/ohs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module ohs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ohs_dp.sv =====
// datapath of the hash set: slot and rehash memories, probe unit, counters, result register
// depends on ohs_pkg and ohs_ram

module ohs_dp import ohs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ohs_op_e              op_i,
  input  logic [1:0]           cmd_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [2:0]           out_status_o,
  output logic [KEY_W-1:0]     out_key_o,
  output logic [CNT_W-1:0]     out_count_o,
  output ohs_dp_status_t       status_o
);

  // architectural state
  logic [SLOT_AW-1:0] mask_q, mask_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   rdptr_q, rdptr_d;
  logic               ovf_q, ovf_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  ohs_cmd_e           cmd_q, cmd_d;

  // probe state
  logic               pl_q, pl_d;
  logic [SLOT_AW-1:0] base_q, base_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [KEY_W-1:0]   pert_q, pert_d;
  logic [KEY_W-1:0]   pkey_q, pkey_d;

  // growth state
  logic [SLOT_AW-1:0] nmask_q, nmask_d;
  logic [SIZE_W-1:0]  size_q, size_d;

  // pending result and output register
  logic [2:0]         res_status_q, res_status_d;
  logic [KEY_W-1:0]   res_key_q, res_key_d;
  logic               out_valid_q, out_valid_d;
  logic [2:0]         out_status_q;
  logic [KEY_W-1:0]   out_key_q;
  logic [CNT_W-1:0]   out_count_q;

  // memory ports
  logic               sl_we, rh_we;
  logic [SLOT_AW-1:0] sl_waddr, rh_waddr, sl_raddr, rh_raddr;
  logic [ENTRY_W-1:0] sl_wdata, rh_wdata, sl_rdata, rh_rdata;

  // probe helpers
  logic [SLOT_AW-1:0] pmask;
  logic [SLOT_AW-1:0] paddr;
  logic               run9;
  logic               grp_last;
  logic [KEY_W-1:0]   pert_nx;
  logic [SLOT_AW-1:0] home_nx;
  logic [ENTRY_W-1:0] prb_data;
  logic               prb_empty;
  logic               prb_match;
  logic [TGT_W-1:0]   target;
  logic [TGT_W-1:0]   used5;
  logic [TGT_W-1:0]   mask3;
  logic               cnt_mask_last;
  logic               cnt_nmask_last;

  ohs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .raddr_i (sl_raddr),
    .rdata_o (sl_rdata)
  );

  ohs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLOTS)) u_rehash_ram (
    .clk_i   (clk_i),
    .we_i    (rh_we),
    .waddr_i (rh_waddr),
    .wdata_i (rh_wdata),
    .raddr_i (rh_raddr),
    .rdata_o (rh_rdata)
  );

  // probe address, linear run bound and next home slot
  assign pmask     = pl_q ? nmask_q : mask_q;
  assign paddr     = base_q + SLOT_AW'(run_q);
  assign run9      = ({1'b0, base_q} + CNT_W'(LINEAR_RUN)) <= {1'b0, pmask};
  assign grp_last  = run9 ? (run_q == RUN_W'(LINEAR_RUN)) : 1'b1;
  assign pert_nx   = pert_q >> PERTURB_SHIFT;
  assign home_nx   = (base_q * SLOT_AW'(5) + SLOT_AW'(1) + pert_nx[SLOT_AW-1:0]) & pmask;
  assign prb_data  = pl_q ? rh_rdata : sl_rdata;
  assign prb_empty = !prb_data[ENTRY_W-1];
  assign prb_match = prb_data[KEY_W-1:0] == pkey_q;

  // growth thresholds
  assign target = ({3'b000, used_q} > TGT_W'(BIG_SET)) ? {2'b00, used_q, 1'b0}
                                                        : {1'b0, used_q, 2'b00};
  assign used5  = {3'b000, used_q} * TGT_W'(5);
  assign mask3  = {4'b0000, mask_q} * TGT_W'(3);

  assign cnt_mask_last  = cnt_q == {1'b0, mask_q};
  assign cnt_nmask_last = cnt_q == {1'b0, nmask_q};

  // memory port selection
  always_comb begin
    sl_we    = 1'b0;
    sl_waddr = cnt_q[SLOT_AW-1:0];
    sl_wdata = '0;
    rh_we    = 1'b0;
    rh_waddr = cnt_q[SLOT_AW-1:0];
    rh_wdata = '0;
    sl_raddr = (op_i == OP_PRB_RD && !pl_q) ? paddr : cnt_q[SLOT_AW-1:0];
    rh_raddr = (op_i == OP_PRB_RD && pl_q) ? paddr : cnt_q[SLOT_AW-1:0];
    case (op_i)
      OP_INIT_WR, OP_CLR_WR: sl_we = 1'b1;
      OP_GCLR_WR:            rh_we = 1'b1;
      OP_COPY_WR: begin
        sl_we    = 1'b1;
        sl_wdata = rh_rdata;
      end
      OP_PRB_CHK: begin
        if (prb_empty) begin
          sl_we    = !pl_q;
          rh_we    = pl_q;
          sl_waddr = paddr;
          rh_waddr = paddr;
          sl_wdata = {1'b1, pkey_q};
          rh_wdata = {1'b1, pkey_q};
        end
      end
      default: ;
    endcase
  end

  // next state of the datapath registers
  always_comb begin
    mask_d       = mask_q;
    used_d       = used_q;
    rdptr_d      = rdptr_q;
    ovf_d        = ovf_q;
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    pl_d         = pl_q;
    base_d       = base_q;
    run_d        = run_q;
    pert_d       = pert_q;
    pkey_d       = pkey_q;
    nmask_d      = nmask_q;
    size_d       = size_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (op_i)
      OP_INIT_WR: cnt_d = cnt_q + CNT_W'(1);
      OP_ACCEPT: begin
        cmd_d     = ohs_cmd_e'(cmd_i);
        pl_d      = 1'b0;
        base_d    = key_i[SLOT_AW-1:0] & mask_q;
        run_d     = '0;
        pert_d    = key_i;
        pkey_d    = key_i;
        res_key_d = '0;
        cnt_d     = (cmd_i == CMD_CLEAR || cmd_i == CMD_INSERT) ? '0 : rdptr_q;
      end
      OP_CLR_WR: begin
        if (cnt_mask_last) begin
          cnt_d        = '0;
          mask_d       = SLOT_AW'(MIN_SLOTS - 1);
          used_d       = '0;
          rdptr_d      = '0;
          ovf_d        = 1'b0;
          res_status_d = ST_CLEARED;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_RES_OVF: res_status_d = ST_OVF_REJ;
      OP_PRB_CHK: begin
        if (prb_empty) begin
          if (!pl_q) begin
            used_d       = used_q + CNT_W'(1);
            res_status_d = ST_INSERTED;
          end
        end else if (prb_match && !pl_q) begin
          res_status_d = ST_PRESENT;
        end else if (grp_last) begin
          base_d = home_nx;
          pert_d = pert_nx;
          run_d  = '0;
        end else begin
          run_d = run_q + RUN_W'(1);
        end
      end
      OP_SIZE_INIT: size_d = SIZE_W'(MIN_SLOTS);
      OP_SIZE_STEP: size_d = size_q << 1;
      OP_SET_OVF:   ovf_d  = 1'b1;
      OP_GROW_BEGIN: begin
        nmask_d = SLOT_AW'(size_q - SIZE_W'(1));
        cnt_d   = '0;
      end
      OP_GCLR_WR: cnt_d = cnt_nmask_last ? '0 : cnt_q + CNT_W'(1);
      OP_PLACE_BEGIN: begin
        pl_d   = 1'b1;
        base_d = sl_rdata[SLOT_AW-1:0] & nmask_q;
        run_d  = '0;
        pert_d = sl_rdata[KEY_W-1:0];
        pkey_d = sl_rdata[KEY_W-1:0];
      end
      OP_SCAN_NEXT: cnt_d = cnt_mask_last ? '0 : cnt_q + CNT_W'(1);
      OP_COPY_WR: begin
        if (cnt_nmask_last) begin
          cnt_d  = '0;
          mask_d = nmask_q;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_RD_EXH: begin
        rdptr_d      = '0;
        res_status_d = ST_READ_EXH;
      end
      OP_RD_HIT: begin
        rdptr_d      = cnt_q + CNT_W'(1);
        res_key_d    = sl_rdata[KEY_W-1:0];
        res_status_d = ST_KEY_READ;
      end
      OP_RD_NEXT:  cnt_d       = cnt_q + CNT_W'(1);
      OP_LOAD_OUT: out_valid_d = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= SLOT_AW'(MIN_SLOTS - 1);
      used_q      <= '0;
      rdptr_q     <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      cmd_q       <= CMD_CLEAR;
      pl_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      used_q      <= used_d;
      rdptr_q     <= rdptr_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      cmd_q       <= cmd_d;
      pl_q        <= pl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    run_q        <= run_d;
    pert_q       <= pert_d;
    pkey_q       <= pkey_d;
    nmask_q      <= nmask_d;
    size_q       <= size_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    if (op_i == OP_LOAD_OUT) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_count_q  <= used_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_key_o    = out_key_q;
  assign out_count_o  = out_count_q;

  // status towards the controller
  always_comb begin
    status_o.cmd            = cmd_q;
    status_o.ovf            = ovf_q;
    status_o.place          = pl_q;
    status_o.prb_empty      = prb_empty;
    status_o.prb_match      = prb_match;
    status_o.slot_valid     = sl_rdata[ENTRY_W-1];
    status_o.grow_need      = used5 >= mask3;
    status_o.size_done      = size_q > {1'b0, target};
    status_o.size_big       = size_q > SIZE_W'(MAX_SLOTS);
    status_o.cnt_max_last   = cnt_q == CNT_W'(MAX_SLOTS - 1);
    status_o.cnt_mask_last  = cnt_mask_last;
    status_o.cnt_nmask_last = cnt_nmask_last;
    status_o.rd_end         = cnt_q > {1'b0, mask_q};
    status_o.out_busy       = out_valid_q && !out_ready_i;
  end

endmodule

// ===== sv/ohs_ctrl.sv =====
// controller state machine of the hash set, issues at most one datapath operation per cycle
// depends on ohs_pkg

module ohs_ctrl import ohs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ohs_dp_status_t status_i,
  output ohs_op_e        op_o
);

  ohs_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and operation
  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        op_o = OP_INIT_WR;
        if (status_i.cnt_max_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_ACCEPT;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.cmd)
          CMD_CLEAR: state_d = S_CLR;
          CMD_INSERT: begin
            if (status_i.ovf) begin
              op_o    = OP_RES_OVF;
              state_d = S_DONE;
            end else begin
              state_d = S_PRB_RD;
            end
          end
          default: state_d = S_RD_RD;
        endcase
      end
      S_CLR: begin
        op_o = OP_CLR_WR;
        if (status_i.cnt_mask_last) state_d = S_DONE;
      end
      S_PRB_RD: begin
        op_o    = OP_PRB_RD;
        state_d = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        op_o = OP_PRB_CHK;
        if (status_i.prb_empty) begin
          state_d = status_i.place ? S_SCAN_NEXT : S_GROW_CHK;
        end else if (status_i.prb_match && !status_i.place) begin
          state_d = S_DONE;
        end else begin
          state_d = S_PRB_RD;
        end
      end
      S_GROW_CHK: begin
        if (status_i.grow_need) begin
          op_o    = OP_SIZE_INIT;
          state_d = S_GROW_SIZE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_GROW_SIZE: begin
        if (!status_i.size_done) begin
          op_o = OP_SIZE_STEP;
        end else if (status_i.size_big) begin
          op_o    = OP_SET_OVF;
          state_d = S_DONE;
        end else begin
          op_o    = OP_GROW_BEGIN;
          state_d = S_GCLR;
        end
      end
      S_GCLR: begin
        op_o = OP_GCLR_WR;
        if (status_i.cnt_nmask_last) state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        op_o    = OP_SCAN_RD;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (status_i.slot_valid) begin
          op_o    = OP_PLACE_BEGIN;
          state_d = S_PRB_RD;
        end else begin
          state_d = S_SCAN_NEXT;
        end
      end
      S_SCAN_NEXT: begin
        op_o    = OP_SCAN_NEXT;
        state_d = status_i.cnt_mask_last ? S_COPY_RD : S_SCAN_RD;
      end
      S_COPY_RD: begin
        op_o    = OP_COPY_RD;
        state_d = S_COPY_WR;
      end
      S_COPY_WR: begin
        op_o    = OP_COPY_WR;
        state_d = status_i.cnt_nmask_last ? S_DONE : S_COPY_RD;
      end
      S_RD_RD: begin
        if (status_i.rd_end) begin
          op_o    = OP_RD_EXH;
          state_d = S_DONE;
        end else begin
          op_o    = OP_RD_RD;
          state_d = S_RD_CHK;
        end
      end
      S_RD_CHK: begin
        if (status_i.slot_valid) begin
          op_o    = OP_RD_HIT;
          state_d = S_DONE;
        end else begin
          op_o    = OP_RD_NEXT;
          state_d = S_RD_RD;
        end
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          op_o    = OP_LOAD_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== sv/open_addressing_hash_set_core.sv =====
// Open-addressing hash set of 31-bit keys. One command per input transfer: clear, insert or
// read the next stored key in slot order; each gives exactly one result transfer. Work is
// sequential through a single-port-read slot memory: an insert probes slots until it finds
// the key or an empty slot, a read scans slots from its read pointer, and a clear writes
// every slot of the current table. An insert that triggers growth adds a sizing step, a
// pass that clears the scratch table, a scan of the old slots that places each key there
// by probing, and a pass that copies the scratch table back. After reset the slot memory is
// cleared before the first transfer is taken. A finished result waits in the output register
// while the next command is accepted. Depends on ohs_pkg, ohs_ctrl, ohs_dp and ohs_ram.

module open_addressing_hash_set_core import ohs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // command[1:0], key[32:2], zero pad
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o   // status[2:0], key_out[33:3], stored_count[46:34]
);

  ohs_op_e          op;
  ohs_dp_status_t   dp_status;
  logic [2:0]       out_status;
  logic [KEY_W-1:0] out_key;
  logic [CNT_W-1:0] out_count;

  ohs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (dp_status),
    .op_o       (op)
  );

  ohs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .cmd_i        (s_axis_tdata_i[1:0]),
    .key_i        (s_axis_tdata_i[KEY_W+1:2]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (out_status),
    .out_key_o    (out_key),
    .out_count_o  (out_count),
    .status_o     (dp_status)
  );

  // pack the result transfer
  assign m_axis_tdata_o = {1'b0, out_count, out_key, out_status};

endmodule

// ===== sv/ohs_checker.sv =====
// port-level checks of the hash set core, attached by bind
// depends on ohs_pkg and open_addressing_hash_set_core

module ohs_checker import ohs_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  // stalled command transfer holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=> s_axis_tvalid_i && $stable(s_axis_tdata_i))
    else $error("command changed while stalled");

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // key only returned by a successful read
  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2:0] != ST_KEY_READ |-> m_axis_tdata_o[33:3] == '0)
    else $error("non-read result carries a key");

  // a clear leaves an empty set
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2:0] == ST_CLEARED |-> m_axis_tdata_o[46:34] == '0)
    else $error("count not zero after clear");

  // count never exceeds the table
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[46:34] <= CNT_W'(MAX_SLOTS))
    else $error("stored count above table size");

endmodule

bind open_addressing_hash_set_core ohs_checker u_ohs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
